### rtl/assert_macros.svh
// Assertion helpers for the parser RTL. Both forms check on the rising clock
// edge and are switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ADV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ADV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ADV_ASSERT(lbl, clk, rstn, prop, msg)
`define ADV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/adv_pkg.sv
package adv_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned TextMaxChars  = 5;
  localparam int unsigned MaxFracDigits = 9;

  localparam int unsigned CountW   = 3;
  localparam int unsigned FracCntW = 4;
  localparam int unsigned AccW     = 32;
  localparam int unsigned WholeW   = 16;
  localparam int unsigned TextW    = 40;
  localparam int unsigned DivNumW  = 48;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned QuoW     = 17;
  localparam int unsigned QuoCntW  = 5;

  localparam logic [2:0] ModeInt   = 3'd0;
  localparam logic [2:0] ModeByte  = 3'd1;
  localparam logic [2:0] ModeHalf  = 3'd2;
  localparam logic [2:0] ModeFixed = 3'd3;
  localparam logic [2:0] ModeText  = 3'd4;

  localparam logic CmdChar = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [AccW-1:0] ByteMax     = 32'd255;
  localparam logic [AccW-1:0] HalfMax     = 32'd65535;
  localparam logic [AccW-1:0] FixWholeMax = 32'd32768;

  typedef struct packed {
    logic       command;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] number;
    logic [39:0]        text_digits;
    logic [2:0]         text_length;
  } out_item_t;

  // Classified character as it sits in the queue.
  typedef struct packed {
    logic       is_end;
    logic       is_digit;
    logic       is_minus;
    logic       is_point;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkDone
  } back_state_e;

  function automatic logic [DivDenW-1:0] pow10(input logic [FracCntW-1:0] n);
    logic [DivDenW-1:0] p;
    case (n)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      default: p = 32'd1000000000;
    endcase
    return p;
  endfunction

endpackage

### rtl/adv_front.sv
`include "assert_macros.svh"

module adv_front import adv_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef  // two or more
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     q_valid_o,
  output tok_t     q_tok_o,
  input  logic     q_pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tok_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  tok_t            tok;
  logic            push, pop;

  always_comb begin
    tok.is_end   = (in_data_i.command == CmdEnd);
    tok.is_digit = (in_data_i.ch >= CharZero) && (in_data_i.ch <= CharNine);
    tok.is_minus = (in_data_i.ch == CharMinus);
    tok.is_point = (in_data_i.ch == CharPoint);
    tok.ch       = in_data_i.ch;
  end

  assign in_stall_o = (cnt_q == CntW'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_tok_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok;
    end
  end

  `ADV_ASSERT(a_cnt_step, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count did not follow a push")

endmodule

### rtl/adv_div.sv
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. The upper numerator bits
// must already be below the divisor, so the quotient fits in QuoW bits.
module adv_div import adv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output div_rsp_t           rsp_o
);

  logic               busy_q, done_q;
  logic [QuoCntW-1:0] cnt_q;
  logic [DivDenW-1:0] rem_q, den_q, trial;
  logic [QuoW-1:0]    low_q, quo_q;
  logic               ge;

  assign trial = {rem_q[DivDenW-2:0], low_q[QuoW-1]};
  assign ge    = (trial >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QuoCntW'(QuoW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == QuoCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DivDenW'(num_i[DivNumW-1:QuoW]);
      low_q <= num_i[QuoW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? trial - den_q : trial;
      low_q <= low_q << 1;
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `ADV_ASSERT_IMPL(a_no_restart, clk_i, rst_ni, start_i, !busy_q, "divider restarted while busy")
  `ADV_ASSERT(a_done_after_last, clk_i, rst_ni, (busy_q && cnt_q == QuoCntW'(1)) |=> done_q, "divider missed its done pulse")

endmodule

### rtl/adv_back.sv
`include "assert_macros.svh"

module adv_back import adv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic      q_valid_i,
  input  tok_t      q_tok_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  back_state_e         state_q, state_d;
  logic [2:0]          mode_q;
  logic [AccW-1:0]     acc_q, acc_d, acc_sat;
  logic [WholeW-1:0]   whole_q, whole_d;
  logic [FracCntW-1:0] frac_cnt_q, frac_cnt_d;
  logic                neg_q, neg_d, point_q, point_d, fail_q, fail_d;
  logic [CountW-1:0]   char_cnt_q, char_cnt_d;
  logic [TextW-1:0]    text_q, text_d, text_ins;
  logic [AccW+3:0]     acc_ten;
  logic                out_valid_q, load_out, div_start;
  out_item_t           out_q, res;
  logic [AccW:0]       limit, fix_mag;
  logic [DivDenW-1:0]  pow_n;
  logic [DivNumW-1:0]  div_num;
  div_rsp_t            div_rsp;

  // Fraction f becomes (f * 2^16 + 10^n / 2) / 10^n.
  assign pow_n   = pow10(frac_cnt_q);
  assign div_num = {acc_q, 16'b0} + DivNumW'(pow_n >> 1);

  adv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (pow_n),
    .rsp_o  (div_rsp)
  );

  // Saturating acc * 10 + digit.
  assign acc_ten = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + {32'b0, q_tok_i.ch[3:0]};
  assign acc_sat = (acc_ten[AccW+3:AccW] != '0) ? '1 : acc_ten[AccW-1:0];
  assign text_ins = TextW'(q_tok_i.ch) << {char_cnt_q, 3'b000};

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    whole_d    = whole_q;
    frac_cnt_d = frac_cnt_q;
    neg_d      = neg_q;
    point_d    = point_q;
    fail_d     = fail_q;
    char_cnt_d = char_cnt_q;
    text_d     = text_q;
    q_pop_o    = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_tok_i.is_end) begin
            if (mode_q == ModeFixed && point_q) begin
              div_start = 1'b1;
              state_d   = BkDiv;
            end else begin
              state_d = BkDone;
            end
          end else begin
            if (mode_q == ModeText) begin
              if (!q_tok_i.is_digit || char_cnt_q >= CountW'(TextMaxChars)) begin
                fail_d = 1'b1;
              end else begin
                text_d = text_q | text_ins;
              end
            end else if (mode_q <= ModeFixed) begin
              if (q_tok_i.is_minus) begin
                if (char_cnt_q == '0) begin
                  neg_d = 1'b1;
                end else begin
                  fail_d = 1'b1;
                end
              end else if (q_tok_i.is_point && mode_q == ModeFixed) begin
                if (point_q || acc_q > FixWholeMax) begin
                  fail_d = 1'b1;
                end else begin
                  point_d = 1'b1;
                  whole_d = acc_q[WholeW-1:0];
                  acc_d   = '0;
                end
              end else if (q_tok_i.is_digit) begin
                if (mode_q == ModeFixed && point_q) begin
                  // Fraction digits past the limit are checked but dropped.
                  if (frac_cnt_q < FracCntW'(MaxFracDigits)) begin
                    acc_d      = acc_sat;
                    frac_cnt_d = frac_cnt_q + 1'b1;
                  end
                end else begin
                  acc_d = acc_sat;
                end
              end else begin
                fail_d = 1'b1;
              end
            end
            if (char_cnt_q < CountW'(TextMaxChars + 1)) begin
              char_cnt_d = char_cnt_q + 1'b1;
            end
          end
        end
      end
      BkDiv: begin
        if (div_rsp.done) begin
          state_d = BkDone;
        end
      end
      BkDone: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out   = 1'b1;
          state_d    = BkIdle;
          acc_d      = '0;
          whole_d    = '0;
          frac_cnt_d = '0;
          neg_d      = 1'b0;
          point_d    = 1'b0;
          fail_d     = 1'b0;
          char_cnt_d = '0;
          text_d     = '0;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  assign limit   = neg_q ? 33'h080000000 : 33'h07FFFFFFF;
  assign fix_mag = point_q ? ({1'b0, whole_q, 16'b0} + {16'b0, div_rsp.quotient})
                           : {acc_q[16:0], 16'b0};

  always_comb begin
    res = '0;
    if (!fail_q) begin
      case (mode_q)
        ModeInt: begin
          if ({1'b0, acc_q} <= limit) begin
            res.ok     = 1'b1;
            res.number = $signed(neg_q ? -acc_q : acc_q);
          end
        end
        ModeByte: begin
          if (!neg_q && acc_q <= ByteMax) begin
            res.ok     = 1'b1;
            res.number = $signed(acc_q);
          end
        end
        ModeHalf: begin
          if (!neg_q && acc_q <= HalfMax) begin
            res.ok     = 1'b1;
            res.number = $signed(acc_q);
          end
        end
        ModeFixed: begin
          if ((point_q || acc_q <= FixWholeMax) && fix_mag <= limit) begin
            res.ok     = 1'b1;
            res.number = $signed(neg_q ? -fix_mag[AccW-1:0] : fix_mag[AccW-1:0]);
          end
        end
        ModeText: begin
          res.ok          = 1'b1;
          res.text_digits = text_q;
          res.text_length = char_cnt_q;
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      mode_q      <= ModeInt;
      acc_q       <= '0;
      whole_q     <= '0;
      frac_cnt_q  <= '0;
      neg_q       <= 1'b0;
      point_q     <= 1'b0;
      fail_q      <= 1'b0;
      char_cnt_q  <= '0;
      text_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      whole_q    <= whole_d;
      frac_cnt_q <= frac_cnt_d;
      neg_q      <= neg_d;
      point_q    <= point_d;
      fail_q     <= fail_d;
      char_cnt_q <= char_cnt_d;
      text_q     <= text_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ADV_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, out_valid_q && !out_q.ok, out_q.number == '0 && out_q.text_digits == '0 && out_q.text_length == '0, "failed result carries data")
  `ADV_ASSERT_IMPL(a_div_wait, clk_i, rst_ni, state_q == BkDiv, div_rsp.busy || div_rsp.done, "waiting on an idle divider")

endmodule

### rtl/ascii_decimal_value_parser_core.sv
// ASCII decimal parser: one character transaction per cycle enters a small
// queue (QueueDepth entries) while not full and is classified there; the
// parse engine behind it consumes one character per cycle while idle. An
// end-of-string transaction yields one result, in Q16.16 mode once a decimal
// point has been seen only after a one-bit-per-cycle divider has scaled the
// fraction. The result sits in an output register, so new characters keep
// flowing into the queue while it waits to be taken. The mode register is
// written through cfg_we_i and must only change while the block is idle.
module ascii_decimal_value_parser_core import adv_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  logic q_valid, q_pop;
  tok_t q_tok;

  adv_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_tok_o   (q_tok),
    .q_pop_i   (q_pop)
  );

  adv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_valid_i  (q_valid),
    .q_tok_i    (q_tok),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### tb/ascii_decimal_value_parser_core_test.sv
`timescale 1ns / 100ps

module ascii_decimal_value_parser_core_test;
  import adv_pkg::*;

  localparam int unsigned LimitCycles  = 300000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ItemsPerMode = 14;
  localparam logic [2:0]  ModeUnused   = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    string       text;
    bit          typed;
    logic        ok;
    logic [31:0] number;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [2:0] cfg_wdata_i = ModeInt;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Shadow of the parse state and the mode register.
  logic [2:0]  mode_shadow;
  logic [31:0] digits_acc;
  logic [15:0] whole_acc;
  logic [3:0]  frac_digits;
  logic        neg_seen;
  logic        point_seen;
  logic        parse_err;
  logic [2:0]  chars_seen;
  logic [39:0] text_bytes;

  out_item_t   expected_values[$];
  out_item_t   oldest_expected;
  logic [7:0]  pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  bit          burst_string = 1'b0;

  dir_row_t dir_rows [28] = '{
    '{ModeInt,    "",                 1, 1'b1, 32'h0000_0000},
    '{ModeInt,    "2147483647",       1, 1'b1, 32'h7FFF_FFFF},
    '{ModeInt,    "-2147483648",      1, 1'b1, 32'h8000_0000},
    '{ModeInt,    "2147483648",       1, 1'b0, 32'h0000_0000},
    '{ModeInt,    "99999999999",      1, 1'b0, 32'h0000_0000},
    '{ModeInt,    "1-2",              1, 1'b0, 32'h0000_0000},
    '{ModeInt,    "-",                1, 1'b1, 32'h0000_0000},
    '{ModeInt,    "7a",               1, 1'b0, 32'h0000_0000},
    '{ModeInt,    "\377",             1, 1'b0, 32'h0000_0000},
    '{ModeInt,    "-00123",           0, 1'b0, 32'h0000_0000},
    '{ModeByte,   "255",              1, 1'b1, 32'h0000_00FF},
    '{ModeByte,   "256",              1, 1'b0, 32'h0000_0000},
    '{ModeByte,   "-0",               1, 1'b0, 32'h0000_0000},
    '{ModeHalf,   "65535",            1, 1'b1, 32'h0000_FFFF},
    '{ModeHalf,   "65536",            1, 1'b0, 32'h0000_0000},
    '{ModeFixed,  "-32768",           1, 1'b1, 32'h8000_0000},
    '{ModeFixed,  "32768",            1, 1'b0, 32'h0000_0000},
    '{ModeFixed,  "1.5",              1, 1'b1, 32'h0001_8000},
    '{ModeFixed,  "-0.5",             1, 1'b1, 32'hFFFF_8000},
    '{ModeFixed,  "1.2.3",            1, 1'b0, 32'h0000_0000},
    '{ModeFixed,  ".",                1, 1'b1, 32'h0000_0000},
    '{ModeFixed,  "32767.9999999999", 0, 1'b0, 32'h0000_0000},
    '{ModeFixed,  "0.123456789123",   0, 1'b0, 32'h0000_0000},
    '{ModeFixed,  "32768.0",          1, 1'b0, 32'h0000_0000},
    '{ModeText,   "",                 1, 1'b1, 32'h0000_0000},
    '{ModeText,   "09123",            0, 1'b0, 32'h0000_0000},
    '{ModeText,   "123456",           1, 1'b0, 32'h0000_0000},
    '{ModeUnused, "12",               1, 1'b0, 32'h0000_0000}
  };

  ascii_decimal_value_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void restart_parse();
    digits_acc  = '0;
    whole_acc   = '0;
    frac_digits = '0;
    neg_seen    = 1'b0;
    point_seen  = 1'b0;
    parse_err   = 1'b0;
    chars_seen  = '0;
    text_bytes  = '0;
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    logic        is_digit;
    logic        add_it;
    logic [63:0] grown;
    is_digit = (c >= CharZero) && (c <= CharNine);
    add_it = 1'b0;
    if (mode_shadow == ModeText) begin
      if (!is_digit || chars_seen >= TextMaxChars) parse_err = 1'b1;
      else text_bytes[8*chars_seen +: 8] = c;
    end else if (mode_shadow <= ModeFixed) begin
      if (c == CharMinus) begin
        // A sign is only legal as the very first character.
        if (chars_seen == 0) neg_seen = 1'b1;
        else parse_err = 1'b1;
      end else if (c == CharPoint && mode_shadow == ModeFixed) begin
        if (point_seen || digits_acc > FixWholeMax) begin
          parse_err = 1'b1;
        end else begin
          point_seen = 1'b1;
          whole_acc  = digits_acc[15:0];
          digits_acc = '0;
        end
      end else if (is_digit) begin
        // Fraction digits beyond the kept count are validated but dropped.
        if (mode_shadow == ModeFixed && point_seen) begin
          if (frac_digits < MaxFracDigits) begin
            add_it = 1'b1;
            frac_digits++;
          end
        end else begin
          add_it = 1'b1;
        end
      end else begin
        parse_err = 1'b1;
      end
    end
    if (add_it) begin
      grown = {32'd0, digits_acc} * 64'd10 + 64'(c - CharZero);
      digits_acc = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
    end
    if (chars_seen < TextMaxChars + 1) chars_seen++;
  endfunction

  function automatic out_item_t close_string();
    out_item_t   res;
    logic [63:0] lim;
    logic [63:0] mag;
    logic [63:0] scale;
    logic [63:0] frac;
    res = '0;
    lim = neg_seen ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (!parse_err) begin
      case (mode_shadow) inside
        ModeInt: begin
          if (digits_acc <= lim) begin
            res.ok = 1'b1;
            res.number = neg_seen ? -digits_acc : digits_acc;
          end
        end
        ModeByte, ModeHalf: begin
          if (!neg_seen && digits_acc <= ((mode_shadow == ModeByte) ? ByteMax : HalfMax)) begin
            res.ok = 1'b1;
            res.number = digits_acc;
          end
        end
        ModeFixed: begin
          mag = '1;
          if (point_seen) begin
            scale = 64'd1;
            for (int i = 0; i < frac_digits; i++) scale = scale * 64'd10;
            // Round to nearest, ties up; the fraction may carry into the whole part.
            frac = ({32'd0, digits_acc} * 64'd65536 + scale / 2) / scale;
            mag = {32'd0, whole_acc, 16'd0} + frac;
          end else if (digits_acc <= FixWholeMax) begin
            mag = {16'd0, digits_acc, 16'd0};
          end
          if (mag <= lim) begin
            res.ok = 1'b1;
            res.number = neg_seen ? -mag[31:0] : mag[31:0];
          end
        end
        ModeText: begin
          res.ok = 1'b1;
          res.text_digits = text_bytes;
          res.text_length = chars_seen;
        end
        default: ;
      endcase
    end
    restart_parse();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Drives one transaction, waits until it is taken, then updates the shadow state.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int unsigned gap;
    out_item_t   res;
    gap = 0;
    if (!burst_string) begin
      while (gap < 12 && $urandom_range(99) < in_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.command == CmdEnd) begin
      res = close_string();
      expected_values.push_back(typed ? typed_res : res);
    end else begin
      feed_char(it.ch);
    end
  endtask

  task automatic send_string(input bit typed, input out_item_t typed_res);
    in_item_t it;
    foreach (pending_chars[i]) begin
      it.command = CmdChar;
      it.ch = pending_chars[i];
      push_item(it, 1'b0, '0);
    end
    it.command = CmdEnd;
    it.ch = 8'($urandom_range(255));
    push_item(it, typed, typed_res);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    // Characters after the last end transaction may still sit in the queue.
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [2:0] m);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_shadow = m;
  endtask

  // Mostly well-formed numbers for the mode, some corrupted, some pure noise.
  task automatic build_random_string(input logic [2:0] m);
    string       digits;
    logic [31:0] v;
    int unsigned pos;
    pending_chars.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(7)) pending_chars.push_back(8'($urandom_range(255)));
    end else begin
      if (m != ModeText && $urandom_range(99) < 25) pending_chars.push_back(CharMinus);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 3)) pending_chars.push_back(CharZero);
      end
      case (m)
        ModeInt: begin
          case ($urandom_range(2))
            0:       v = $urandom;
            1:       v = 32'h7FFF_FFF8 + $urandom_range(15);
            default: v = $urandom_range(999);
          endcase
        end
        ModeByte:  v = $urandom_range(300);
        ModeHalf:  v = $urandom_range(1) ? $urandom_range(65540, 65530) : $urandom_range(70000);
        ModeFixed: v = ($urandom_range(3) == 0) ? $urandom_range(32770, 32765)
                                                : $urandom_range(200);
        default:   v = $urandom_range(99);
      endcase
      if (m == ModeText) begin
        repeat ($urandom_range(6)) pending_chars.push_back(8'(CharZero + $urandom_range(9)));
      end else if (!(m == ModeFixed && $urandom_range(99) < 10)) begin
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) pending_chars.push_back(digits[i]);
      end
      if (m == ModeInt && $urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 3)) pending_chars.push_back(8'(CharZero + $urandom_range(9)));
      end
      if (m == ModeFixed && $urandom_range(99) < 70) begin
        pending_chars.push_back(CharPoint);
        repeat ($urandom_range(12)) begin
          pending_chars.push_back(8'(CharZero + $urandom_range(9)));
        end
      end
      if ($urandom_range(99) < 10) begin
        if (pending_chars.size() == 0) pending_chars.push_back(CharZero);
        pos = $urandom_range(pending_chars.size() - 1);
        case ($urandom_range(2))
          0:       pending_chars[pos] = 8'($urandom_range(255));
          1:       pending_chars[pos] = CharMinus;
          default: pending_chars[pos] = CharPoint;
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_data_o.number), '0);
        end else begin
          oldest_expected = expected_values.pop_front();
          if (out_data_o.ok !== oldest_expected.ok)
            report_mismatch("ok", 64'(out_data_o.ok), 64'(oldest_expected.ok));
          if (out_data_o.number !== oldest_expected.number)
            report_mismatch("number", 64'(unsigned'(out_data_o.number)),
                            64'(unsigned'(oldest_expected.number)));
          if (out_data_o.text_digits !== oldest_expected.text_digits)
            report_mismatch("text_digits", 64'(out_data_o.text_digits),
                            64'(oldest_expected.text_digits));
          if (out_data_o.text_length !== oldest_expected.text_length)
            report_mismatch("text_length", 64'(out_data_o.text_length),
                            64'(oldest_expected.text_length));
        end
      end
      // Back pressure is off entirely whenever cycle_count[5:4] is zero.
      out_stall_i <= (cycle_count[5:4] != 2'd0) && ($urandom_range(99) < out_stall_pct);
    end
  end

  initial begin
    out_item_t   want;
    int unsigned items_sent;
    mode_shadow = ModeInt;
    restart_parse();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != mode_shadow) set_mode(dir_rows[r].mode);
      pending_chars.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) pending_chars.push_back(dir_rows[r].text[i]);
      want = '0;
      want.ok = dir_rows[r].ok;
      want.number = dir_rows[r].number;
      send_string(dir_rows[r].typed, want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 55; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 55; end
        default: begin in_idle_pct = 27; out_stall_pct = 27; end
      endcase
      for (int mi = 0; mi < 5; mi++) begin
        set_mode(3'((mi + ph) % 5));
        items_sent = 0;
        while (items_sent < ItemsPerMode) begin
          build_random_string(mode_shadow);
          burst_string = ($urandom_range(99) < 20);
          items_sent += pending_chars.size() + 1;
          send_string(1'b0, '0);
        end
        burst_string = 1'b0;
      end
    end

    // Modes without a defined conversion swallow characters and always fail.
    for (int m = 5; m < 8; m++) begin
      set_mode(3'(m));
      repeat (2) begin
        build_random_string(mode_shadow);
        send_string(1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
